// ===== hw/rtl/kto_pkg.sv =====
// shared constants and types for the keyed table with oldest-entry replacement
package kto_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int FUNC_W    = 3;
    localparam int SLOT_W    = 6;
    localparam int PART_W    = 8;
    localparam int KEY_W     = 3 * PART_W;
    localparam int TIME_W    = 32;
    localparam int MINUTES_W = 16;
    localparam int STATUS_W  = 2;

    localparam int SEC_PER_MIN = 60;

    localparam logic [FUNC_W-1:0] FN_WRITE      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOOKUP     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR_SLOT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR_ALL  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_EXPIRE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_VICTIM = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADKEY = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

endpackage

// ===== hw/rtl/keyed_table_oldest_replacement_top.sv =====
// keyed device table with lookup, victim choice, clearing and aged-entry expiry
//
// a command word is taken at a rising edge where start is high and busy is low.
// write, clear slot, clear all, undefined codes and a lookup with id zero finish
// at once: done pulses in the cycle after the accept and busy never rises, so a
// new command may follow in the very next cycle.
// lookup and expire scan the table one entry per cycle through the single read
// port of the entry memory; one subtractor serves both the oldest-time compare
// and the age computation. such a command keeps busy high through the scan, and
// done pulses in the cycle busy falls.
// each result word (slot_out, status) is shown for exactly one cycle with done;
// the receiver cannot stall, so nothing is held back.
// reset clears busy, done and every entry valid bit, which makes the whole table
// read as zero keys and zero times; no clearing pass is needed. clear all and
// expiry also act only on the valid bits.
module keyed_table_oldest_replacement_top #(
    parameter int TABLE_ENTRIES = kto_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [kto_pkg::FUNC_W-1:0]        func,
    input  logic [kto_pkg::SLOT_W-1:0]        slot_in,
    input  logic [kto_pkg::PART_W-1:0]        node_key,
    input  logic [kto_pkg::PART_W-1:0]        type_key,
    input  logic [kto_pkg::PART_W-1:0]        id_key,
    input  logic [kto_pkg::TIME_W-1:0]        time_stamp,
    input  logic                              want_victim,
    input  logic [kto_pkg::MINUTES_W-1:0]     age_minutes,
    output logic                              done,
    output logic [kto_pkg::SLOT_W-1:0]        slot_out,
    output logic [kto_pkg::STATUS_W-1:0]      status
);
    import kto_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int WIDE_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [WIDE_W-1:0] DEPTH_W  = WIDE_W'(TABLE_ENTRIES);

    state_t                    state_reg, state_next;
    logic                      issue_reg, issue_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      rd_live_reg, rd_live_next;
    logic                      rd_last_reg, rd_last_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]          rd_idx_reg, rd_idx_next;
    logic [KEY_W+TIME_W-1:0]   rd_data_reg;
    logic [TABLE_ENTRIES-1:0]  valid_reg, valid_next;
    logic [FUNC_W-1:0]         func_reg, func_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic [TIME_W-1:0]         ts_reg, ts_next;
    logic                      victim_reg, victim_next;
    logic [TIME_W-1:0]         limit_reg, limit_next;
    logic                      hit_reg, hit_next;
    logic [IDX_W-1:0]          hit_idx_reg, hit_idx_next;
    logic                      zero_reg, zero_next;
    logic [IDX_W-1:0]          zero_idx_reg, zero_idx_next;
    logic [IDX_W-1:0]          cand_idx_reg, cand_idx_next;
    logic [TIME_W-1:0]         cand_time_reg, cand_time_next;
    logic                      done_reg, done_next;
    logic [SLOT_W-1:0]         slot_out_reg, slot_out_next;
    logic [STATUS_W-1:0]       status_reg, status_next;

    logic [KEY_W+TIME_W-1:0]   mem [TABLE_ENTRIES];

    logic                      accept;
    logic [WIDE_W-1:0]         slot_wide;
    logic                      in_range;
    logic [IDX_W-1:0]          slot_idx;
    logic [KEY_W-1:0]          in_key;
    logic [KEY_W-1:0]          key_e;
    logic [TIME_W-1:0]         time_e;
    logic                      is_expire;
    logic [TIME_W-1:0]         op_a, op_b;
    logic [TIME_W:0]           diff;
    logic                      time_lt;
    logic                      age_over;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign slot_wide = WIDE_W'(slot_in);
    assign in_range  = (slot_wide < DEPTH_W);
    assign slot_idx  = slot_wide[IDX_W-1:0];
    assign in_key    = {node_key, type_key, id_key};

    assign key_e  = rd_valid_reg ? rd_data_reg[KEY_W+TIME_W-1:TIME_W] : '0;
    assign time_e = rd_valid_reg ? rd_data_reg[TIME_W-1:0] : '0;

    // shared subtractor: age for expiry, time order for the victim candidate
    assign is_expire = (func_reg == FN_EXPIRE);
    assign op_a      = is_expire ? ts_reg : time_e;
    assign op_b      = is_expire ? time_e : cand_time_reg;
    assign diff      = {1'b0, op_a} - {1'b0, op_b};
    assign time_lt   = diff[TIME_W];
    assign age_over  = (diff[TIME_W-1:0] > limit_reg);

    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        idx_next       = idx_reg;
        rd_live_next   = 1'b0;
        rd_last_next   = rd_last_reg;
        rd_valid_next  = rd_valid_reg;
        rd_idx_next    = rd_idx_reg;
        valid_next     = valid_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        ts_next        = ts_reg;
        victim_next    = victim_reg;
        limit_next     = limit_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        zero_next      = zero_reg;
        zero_idx_next  = zero_idx_reg;
        cand_idx_next  = cand_idx_reg;
        cand_time_next = cand_time_reg;
        done_next      = 1'b0;
        slot_out_next  = slot_out_reg;
        status_next    = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next      = func;
                    key_next       = in_key;
                    ts_next        = time_stamp;
                    victim_next    = want_victim;
                    limit_next     = TIME_W'(32'(age_minutes) * 32'(SEC_PER_MIN));
                    issue_next     = 1'b1;
                    idx_next       = '0;
                    hit_next       = 1'b0;
                    hit_idx_next   = '0;
                    zero_next      = 1'b0;
                    zero_idx_next  = '0;
                    cand_idx_next  = '0;
                    cand_time_next = '0;
                    slot_out_next  = '0;
                    status_next    = ST_DONE;
                    case (func)
                        FN_WRITE, FN_CLEAR_SLOT:
                        begin
                            done_next     = 1'b1;
                            slot_out_next = slot_in;
                            status_next   = in_range ? ST_DONE : ST_MISS;
                            if (in_range)
                            begin
                                valid_next[slot_idx] = (func == FN_WRITE);
                            end
                        end
                        FN_LOOKUP:
                        begin
                            if (id_key == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BADKEY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        FN_CLEAR_ALL:
                        begin
                            valid_next = '0;
                            done_next  = 1'b1;
                        end
                        FN_EXPIRE:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // read side: one entry per cycle
                if (issue_reg)
                begin
                    rd_live_next  = 1'b1;
                    rd_idx_next   = idx_reg;
                    rd_last_next  = (idx_reg == LAST_IDX);
                    rd_valid_next = valid_reg[idx_reg];
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end

                // compare side
                if (rd_live_reg)
                begin
                    if (is_expire)
                    begin
                        if ((key_e[PART_W-1:0] != '0) && (time_e != '0) && age_over)
                        begin
                            valid_next[rd_idx_reg] = 1'b0;
                        end
                    end
                    else
                    begin
                        if (!hit_reg && (key_e == key_reg))
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = rd_idx_reg;
                        end
                        if (!zero_reg && (key_e == '0))
                        begin
                            zero_next     = 1'b1;
                            zero_idx_next = rd_idx_reg;
                        end
                        if (cand_time_reg == '0)
                        begin
                            cand_idx_next  = rd_idx_reg;
                            cand_time_next = time_e;
                        end
                        else if ((time_e != '0) && time_lt)
                        begin
                            cand_idx_next  = rd_idx_reg;
                            cand_time_next = time_e;
                        end
                    end

                    if (rd_last_reg)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        if (is_expire)
                        begin
                            slot_out_next = '0;
                            status_next   = ST_DONE;
                        end
                        else if (hit_next)
                        begin
                            slot_out_next = SLOT_W'(WIDE_W'(hit_idx_next));
                            status_next   = ST_DONE;
                        end
                        else if (victim_reg)
                        begin
                            slot_out_next = zero_next ? SLOT_W'(WIDE_W'(zero_idx_next))
                                                      : SLOT_W'(WIDE_W'(cand_idx_next));
                            status_next   = ST_VICTIM;
                        end
                        else
                        begin
                            slot_out_next = '0;
                            status_next   = ST_MISS;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            issue_reg   <= 1'b0;
            rd_live_reg <= 1'b0;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            rd_live_reg <= rd_live_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        rd_last_reg   <= rd_last_next;
        rd_valid_reg  <= rd_valid_next;
        rd_idx_reg    <= rd_idx_next;
        func_reg      <= func_next;
        key_reg       <= key_next;
        ts_reg        <= ts_next;
        victim_reg    <= victim_next;
        limit_reg     <= limit_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        zero_reg      <= zero_next;
        zero_idx_reg  <= zero_idx_next;
        cand_idx_reg  <= cand_idx_next;
        cand_time_reg <= cand_time_next;
        slot_out_reg  <= slot_out_next;
        status_reg    <= status_next;
    end

    // entry memory: written on accept of a write, read while scanning
    always_ff @(posedge clk)
    begin
        if (accept && (func == FN_WRITE) && in_range)
        begin
            mem[slot_idx] <= {in_key, time_stamp};
        end
        if ((state_reg == S_SCAN) && issue_reg)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    assign done     = done_reg;
    assign slot_out = slot_out_reg;
    assign status   = status_reg;

    a_clear_all_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FN_CLEAR_ALL)) |=> (valid_reg == '0))
        else $error("clear all left valid entries");

    a_scan_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && rd_live_reg && rd_last_reg) |=> (done && !busy))
        else $error("scan end without a result word");

    a_victim_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_VICTIM)) |-> (WIDE_W'(slot_out) < DEPTH_W))
        else $error("victim slot outside the table");

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the keyed device table: directed table, then random episodes
`timescale 1ns / 1ps

module testbench;
    import kto_pkg::*;

    localparam int ENTRIES = TABLE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1880;
    localparam logic [FUNC_W-1:0] FN_RSVD_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [SLOT_W-1:0]    slot;
        logic [PART_W-1:0]    node_key;
        logic [PART_W-1:0]    type_key;
        logic [PART_W-1:0]    id_key;
        logic [TIME_W-1:0]    stamp;
        logic                 victim;
        logic [MINUTES_W-1:0] minutes;
        logic                 typed;
        logic [SLOT_W-1:0]    exp_slot;
        logic [STATUS_W-1:0]  exp_status;
    } word_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    word_t cmd = '0;
    logic busy;
    logic done;
    logic [SLOT_W-1:0] slot_out;
    logic [STATUS_W-1:0] status;

    logic [KEY_W-1:0] key_mirror [ENTRIES];
    logic [TIME_W-1:0] stamp_mirror [ENTRIES];
    logic [KEY_W-1:0] key_pool [16];
    reply_t expected_replies [$];
    word_t directed_plan [$];
    int fault_count = 0;
    int words_sent = 0;
    int phase = 0;

    keyed_table_oldest_replacement_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (cmd.func),
        .slot_in     (cmd.slot),
        .node_key    (cmd.node_key),
        .type_key    (cmd.type_key),
        .id_key      (cmd.id_key),
        .time_stamp  (cmd.stamp),
        .want_victim (cmd.victim),
        .age_minutes (cmd.minutes),
        .done        (done),
        .slot_out    (slot_out),
        .status      (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("keyed_table_oldest_replacement_top regression: fail");
        $finish;
    end

    function automatic reply_t registry_reply(input word_t w);
        reply_t r;
        logic [KEY_W-1:0] key;
        logic [TIME_W-1:0] limit;
        logic [TIME_W-1:0] age;
        int hit;
        int cand;
        int chosen;
        r.slot = '0;
        r.status = ST_DONE;
        key = {w.node_key, w.type_key, w.id_key};
        case (w.func)
            FN_WRITE, FN_CLEAR_SLOT:
            begin
                r.slot = w.slot;
                if (int'(w.slot) >= ENTRIES)
                    r.status = ST_MISS;
                else if (w.func == FN_WRITE)
                begin
                    key_mirror[w.slot] = key;
                    stamp_mirror[w.slot] = w.stamp;
                end
                else
                begin
                    key_mirror[w.slot] = '0;
                    stamp_mirror[w.slot] = '0;
                end
            end
            FN_LOOKUP:
            begin
                if (w.id_key == '0)
                    r.status = ST_BADKEY;
                else
                begin
                    hit = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (hit < 0 && key_mirror[i] == key)
                            hit = i;
                    if (hit >= 0)
                        r.slot = SLOT_W'(hit);
                    else if (w.victim)
                    begin
                        cand = 0;
                        chosen = -1;
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (chosen < 0)
                            begin
                                if (key_mirror[i] == '0)
                                    chosen = i;
                                else if (stamp_mirror[cand] == '0)
                                    cand = i;
                                else if (stamp_mirror[i] != '0 &&
                                         stamp_mirror[i] < stamp_mirror[cand])
                                    cand = i;
                            end
                        end
                        r.slot = SLOT_W'(chosen >= 0 ? chosen : cand);
                        r.status = ST_VICTIM;
                    end
                    else
                        r.status = ST_MISS;
                end
            end
            FN_CLEAR_ALL:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    key_mirror[i] = '0;
                    stamp_mirror[i] = '0;
                end
            end
            FN_EXPIRE:
            begin
                limit = TIME_W'(w.minutes) * TIME_W'(SEC_PER_MIN);
                for (int i = 0; i < ENTRIES; i++)
                begin
                    age = w.stamp - stamp_mirror[i];
                    if (key_mirror[i][PART_W-1:0] != '0 && stamp_mirror[i] != '0 &&
                        age > limit)
                    begin
                        key_mirror[i] = '0;
                        stamp_mirror[i] = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        reply_t want;
        reply_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got.slot = slot_out;
                got.status = status;
                if (expected_replies.size() == 0)
                begin
                    $display("%0t unexpected word: slot_out %0d status %0d",
                             $time, got.slot, got.status);
                    fault_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.slot !== want.slot)
                    begin
                        $display("%0t slot_out mismatch: expected %0d actual %0d",
                                 $time, want.slot, got.slot);
                        fault_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, got.status);
                        fault_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                want = registry_reply(cmd);
                if (cmd.typed)
                begin
                    want.slot = cmd.exp_slot;
                    want.status = cmd.exp_status;
                end
                expected_replies.push_back(want);
            end
        end
    end

    task automatic issue(input word_t w);
        cmd <= w;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                           input logic [KEY_W-1:0] k, input logic [TIME_W-1:0] ts,
                           input logic v, input logic [MINUTES_W-1:0] m, input logic typed,
                           input logic [SLOT_W-1:0] es, input logic [STATUS_W-1:0] est);
        word_t w;
        w = '0;
        w.func = f;
        w.slot = s;
        {w.node_key, w.type_key, w.id_key} = k;
        w.stamp = ts;
        w.victim = v;
        w.minutes = m;
        w.typed = typed;
        w.exp_slot = es;
        w.exp_status = est;
        directed_plan.push_back(w);
    endtask

    function automatic logic [TIME_W-1:0] entry_stamp(input logic [TIME_W-1:0] base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 15)
            return $urandom();
        return base + TIME_W'($urandom_range(0, 40));
    endfunction

    function automatic word_t random_word(input logic [TIME_W-1:0] base);
        word_t w;
        int r;
        w = '0;
        w.slot = SLOT_W'($urandom());
        {w.node_key, w.type_key, w.id_key} = KEY_W'($urandom());
        w.stamp = $urandom();
        w.victim = 1'($urandom());
        w.minutes = MINUTES_W'($urandom());
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            w.func = FN_WRITE;
            r = $urandom_range(0, 99);
            if (r < 60)
                {w.node_key, w.type_key, w.id_key} = key_pool[$urandom_range(0, 15)];
            else if (r < 65)
                {w.node_key, w.type_key, w.id_key} = '0;
            w.stamp = entry_stamp(base);
        end
        else if (r < 68)
        begin
            w.func = FN_LOOKUP;
            r = $urandom_range(0, 99);
            if (r < 55)
                {w.node_key, w.type_key, w.id_key} = key_pool[$urandom_range(0, 15)];
            else if (r < 60)
                w.id_key = '0;
            w.victim = ($urandom_range(0, 99) < 75);
        end
        else if (r < 78)
            w.func = FN_CLEAR_SLOT;
        else if (r < 80)
            w.func = FN_CLEAR_ALL;
        else if (r < 92)
        begin
            w.func = FN_EXPIRE;
            w.stamp = base + TIME_W'($urandom_range(0, 200));
            if ($urandom_range(0, 99) < 80)
                w.minutes = MINUTES_W'($urandom_range(0, 3));
        end
        else
            w.func = FN_RSVD_LO + FUNC_W'($urandom_range(0, FN_RSVD_HI - FN_RSVD_LO));
        return w;
    endfunction

    task automatic send_paced(input word_t w);
        int next_phase;
        int idle_pct;
        next_phase = words_sent * 3 / RANDOM_ITEMS;
        if (next_phase != phase)
        begin
            drain();
            phase = next_phase;
        end
        idle_pct = (phase == 0) ? 28 : (phase == 1) ? 51 : 0;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 80)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        issue(w);
        words_sent++;
    endtask

    initial
    begin
        word_t w;
        logic [TIME_W-1:0] base;
        int ops;
        for (int i = 0; i < 16; i++)
            key_pool[i] = {16'($urandom()), 8'($urandom_range(1, 255))};
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_mirror[i] = '0;
            stamp_mirror[i] = '0;
        end

        add_row(FN_LOOKUP, 6'd0, 24'h000000, 32'd0, 1'b1, 16'd0, 1'b1, 6'd0, ST_BADKEY);
        add_row(FN_LOOKUP, 6'd0, 24'h010203, 32'd0, 1'b0, 16'd0, 1'b1, 6'd0, ST_MISS);
        add_row(FN_LOOKUP, 6'd0, 24'h010203, 32'd0, 1'b1, 16'd0, 1'b1, 6'd0, ST_VICTIM);
        add_row(FN_WRITE, 6'd0, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0, 16'd0, 1'b1, 6'd0, ST_DONE);
        add_row(FN_WRITE, 6'd63, 24'h010203, 32'd1, 1'b0, 16'd0, 1'b1, 6'd63, ST_DONE);
        add_row(FN_LOOKUP, 6'd0, 24'hFFFFFF, 32'd0, 1'b1, 16'd0, 1'b1, 6'd0, ST_DONE);
        add_row(FN_LOOKUP, 6'd0, 24'h010203, 32'd0, 1'b0, 16'd0, 1'b1, 6'd63, ST_DONE);
        add_row(FN_LOOKUP, 6'd0, 24'hFFFF00, 32'd0, 1'b1, 16'd0, 1'b1, 6'd0, ST_BADKEY);
        add_row(FN_LOOKUP, 6'd0, 24'h0A0B0C, 32'd0, 1'b1, 16'd0, 1'b1, 6'd1, ST_VICTIM);
        add_row(FN_WRITE, 6'd1, 24'h000000, 32'd5, 1'b0, 16'd0, 1'b1, 6'd1, ST_DONE);
        add_row(FN_LOOKUP, 6'd0, 24'h0A0B0C, 32'd0, 1'b1, 16'd0, 1'b1, 6'd1, ST_VICTIM);
        add_row(FN_RSVD_LO, 6'd63, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 16'hFFFF,
                1'b1, 6'd0, ST_DONE);
        add_row(FN_RSVD_LO + 3'd1, 6'd9, 24'h123456, 32'd7, 1'b0, 16'd1, 1'b1, 6'd0, ST_DONE);
        add_row(FN_RSVD_HI, 6'd9, 24'h654321, 32'd7, 1'b1, 16'd1, 1'b1, 6'd0, ST_DONE);
        add_row(FN_CLEAR_SLOT, 6'd63, 24'h0, 32'd0, 1'b0, 16'd0, 1'b1, 6'd63, ST_DONE);
        add_row(FN_LOOKUP, 6'd0, 24'h010203, 32'd0, 1'b0, 16'd0, 1'b1, 6'd0, ST_MISS);
        add_row(FN_WRITE, 6'd5, 24'h112233, 32'hFFFFFFF0, 1'b0, 16'd0, 1'b0, 6'd0, ST_DONE);
        add_row(FN_EXPIRE, 6'd0, 24'h0, 32'h00000010, 1'b0, 16'd0, 1'b1, 6'd0, ST_DONE);
        add_row(FN_LOOKUP, 6'd0, 24'h112233, 32'd0, 1'b0, 16'd0, 1'b0, 6'd0, ST_DONE);
        add_row(FN_WRITE, 6'd2, 24'h440000, 32'd100, 1'b0, 16'd0, 1'b0, 6'd0, ST_DONE);
        add_row(FN_EXPIRE, 6'd0, 24'h0, 32'hFFFFFFFF, 1'b0, 16'hFFFF, 1'b1, 6'd0, ST_DONE);
        add_row(FN_LOOKUP, 6'd0, 24'h778899, 32'd0, 1'b1, 16'd0, 1'b0, 6'd0, ST_DONE);
        add_row(FN_CLEAR_ALL, 6'd63, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 16'hFFFF,
                1'b1, 6'd0, ST_DONE);
        add_row(FN_LOOKUP, 6'd0, 24'hFFFFFF, 32'd0, 1'b1, 16'd0, 1'b1, 6'd0, ST_VICTIM);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            issue(directed_plan[i]);
        drain();

        while (words_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                base = 32'hFFFFFF00 + TIME_W'($urandom_range(0, 255));
            else
                base = $urandom();
            if ($urandom_range(0, 2) == 0)
            begin
                for (int s = 0; s < ENTRIES; s++)
                begin
                    w = random_word(base);
                    w.func = FN_WRITE;
                    w.slot = SLOT_W'(s);
                    {w.node_key, w.type_key, w.id_key} = key_pool[$urandom_range(0, 15)];
                    w.stamp = entry_stamp(base);
                    send_paced(w);
                end
            end
            ops = $urandom_range(20, 60);
            repeat (ops)
                send_paced(random_word(base));
        end

        drain();
        repeat (ENTRIES + 4) @(posedge clk);
        if (fault_count == 0)
            $display("keyed_table_oldest_replacement_top regression: pass");
        else
            $display("keyed_table_oldest_replacement_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/kto_pkg.sv
hw/rtl/keyed_table_oldest_replacement_top.sv
bench/testbench.sv
